/* hdl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// shared types, constants and helpers for the minimum tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

	localparam int unsigned MTS_DEPTH   = 64;
	localparam int unsigned MTS_CNT_W   = $clog2(MTS_DEPTH + 1);
	localparam int unsigned MTS_WORD_W  = 32;
	localparam int unsigned MTS_ENTRY_W = MTS_WORD_W + 2;

	typedef logic [MTS_CNT_W-1:0]           cnt_t;
	typedef logic signed [MTS_WORD_W-1:0]   word_t;
	typedef logic signed [MTS_ENTRY_W-1:0]  entry_t;

	typedef enum logic [0:0] {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_POP_EMPTY = 2'd1,
		STATUS_PUSH_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

	function automatic entry_t widen(input word_t w);
		widen = {{2{w[MTS_WORD_W-1]}}, w};
	endfunction

	// entries below the minimum decode as the minimum itself
	function automatic word_t decode(input entry_t e, input word_t m);
		decode = (e < widen(m)) ? m : e[MTS_WORD_W-1:0];
	endfunction

endpackage

/* hdl/min_tracking_stack.sv */
// ----------------------------------------------------------------------------
// min_tracking_stack
// stack of signed words that also reports its minimum in constant time
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_stall  | op, value
//  out     | out_valid / out_stall| top_value, min_value, is_empty, status
//
//  one transfer per cycle each way while out_stall is low; a result appears
//  in the cycle after its input transfer, held in a single output register
//  the top of stack is slot 0 of a shift chain, so push and pop shift every
//  slot at once whatever the depth
//  reset clears the fill count, the minimum and the output valid at once
//  in_stall rises only while a result is held and out_stall is high
// ----------------------------------------------------------------------------
module min_tracking_stack (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] top_value,
	output logic [31:0] min_value,
	output logic        is_empty,
	output logic [1:0]  status
);

	mts_pkg::cnt_t       count_q;
	mts_pkg::word_t      min_q;
	logic                out_valid_q;
	mts_pkg::word_t      top_q;
	mts_pkg::word_t      omin_q;
	logic                empty_q;
	mts_pkg::status_t    status_q;

	mts_pkg::entry_t     entries [mts_pkg::MTS_DEPTH];
	mts_pkg::cell_ctrl_t cctrl;

	logic                acc_in;
	logic                is_push;
	logic                empty_now;
	logic                full_now;
	logic                pop_last;
	logic                push_below;
	mts_pkg::word_t      val_s;
	mts_pkg::entry_t     v_ext;
	mts_pkg::entry_t     m_ext;
	mts_pkg::entry_t     push_store;
	mts_pkg::entry_t     pop_min_x;
	mts_pkg::word_t      pop_min;

	mts_pkg::cnt_t       count_d;
	mts_pkg::word_t      min_d;
	mts_pkg::word_t      top_d;
	mts_pkg::word_t      omin_d;
	logic                empty_d;
	mts_pkg::status_t    status_d;

	assign acc_in    = in_valid && !in_stall;
	assign in_stall  = out_valid_q && out_stall;
	assign is_push   = (op == mts_pkg::OP_PUSH);
	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == mts_pkg::cnt_t'(mts_pkg::MTS_DEPTH));
	assign pop_last  = (count_q == mts_pkg::cnt_t'(1));
	assign val_s     = value;
	assign v_ext     = mts_pkg::widen(val_s);
	assign m_ext     = mts_pkg::widen(min_q);

	assign push_below = v_ext < m_ext;
	assign push_store = (!empty_now && push_below) ? ((v_ext <<< 1) - m_ext) : v_ext;
	assign pop_min_x  = (entries[0] < m_ext) ? ((m_ext <<< 1) - entries[0]) : m_ext;
	assign pop_min    = pop_min_x[mts_pkg::MTS_WORD_W-1:0];

	assign cctrl.push = acc_in && is_push && !full_now;
	assign cctrl.pop  = acc_in && !is_push && !empty_now;

	// shift chain of slots, slot 0 is the top
	for (genvar i = 0; i < mts_pkg::MTS_DEPTH; i++) begin : g_cell
		mts_pkg::entry_t above;
		mts_pkg::entry_t below;
		if (i == 0) begin : g_first
			assign above = push_store;
		end else begin : g_mid
			assign above = entries[i-1];
		end
		if (i == mts_pkg::MTS_DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_inner
			assign below = entries[i+1];
		end
		mts_cell u_cell (
			.clk   (clk),
			.ctrl  (cctrl),
			.above (above),
			.below (below),
			.entry (entries[i])
		);
	end

	always_comb begin
		count_d  = count_q;
		min_d    = min_q;
		top_d    = '0;
		omin_d   = '0;
		empty_d  = 1'b1;
		status_d = mts_pkg::STATUS_OK;
		if (is_push) begin
			if (full_now) begin
				status_d = mts_pkg::STATUS_PUSH_FULL;
				top_d    = mts_pkg::decode(entries[0], min_q);
				omin_d   = min_q;
				empty_d  = 1'b0;
			end else begin
				count_d = count_q + mts_pkg::cnt_t'(1);
				min_d   = (empty_now || push_below) ? val_s : min_q;
				top_d   = val_s;
				omin_d  = min_d;
				empty_d = 1'b0;
			end
		end else begin
			if (empty_now) begin
				status_d = mts_pkg::STATUS_POP_EMPTY;
			end else if (pop_last) begin
				count_d = '0;
				min_d   = '0;
			end else begin
				count_d = count_q - mts_pkg::cnt_t'(1);
				min_d   = pop_min;
				top_d   = mts_pkg::decode(entries[1], pop_min);
				omin_d  = pop_min;
				empty_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			min_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_in) begin
				count_q     <= count_d;
				min_q       <= min_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			top_q    <= top_d;
			omin_q   <= omin_d;
			empty_q  <= empty_d;
			status_q <= status_d;
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = top_q;
	assign min_value = omin_q;
	assign is_empty  = empty_q;
	assign status    = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mts_pkg::cnt_t'(mts_pkg::MTS_DEPTH))
		else $error("fill count beyond depth");

	a_min_zero_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (min_q == '0))
		else $error("minimum not cleared while empty");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && is_push && !full_now) |=> (count_q == $past(count_q) + mts_pkg::cnt_t'(1)))
		else $error("push did not grow the stack");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (top_q == '0 && omin_q == '0))
		else $error("empty result with non-zero fields");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == mts_pkg::STATUS_PUSH_FULL) |-> !empty_q)
		else $error("push on full reported an empty stack");

endmodule

/* hdl/mts_cell.sv */
// ----------------------------------------------------------------------------
// mts_cell
// one stack slot; shifts down on push and up on pop
// ----------------------------------------------------------------------------
module mts_cell (
	input  logic               clk,
	input  mts_pkg::cell_ctrl_t ctrl,
	input  mts_pkg::entry_t    above,
	input  mts_pkg::entry_t    below,
	output mts_pkg::entry_t    entry
);

	mts_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= above;
		end else if (ctrl.pop) begin
			entry_q <= below;
		end
	end

	assign entry = entry_q;

endmodule
